/* hdl/urs_pkg.sv */
// Shared types and constants for the USBTMC bulk-IN response segmenter.
// No dependencies; imported by every module of the block.
package urs_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;

    localparam int ACTION_W   = 3;
    localparam int FETCH_W    = 12;
    localparam int TSIZE_W    = 32;
    localparam int OFFSET_W   = 12;
    localparam int LENGTH_W   = 13;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 48;

    localparam logic [7:0] STB_MAV = 8'h10;
    localparam logic [7:0] STB_SRQ = 8'h40;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND      = 3'd0,
        ACT_IN_REQUEST  = 3'd1,
        ACT_IN_COMPLETE = 3'd2,
        ACT_READ_STATUS = 3'd3,
        ACT_SET_SRQ     = 3'd4,
        ACT_CLEAR_OUT   = 3'd5,
        ACT_CLEAR_IN    = 3'd6,
        ACT_FETCH       = 3'd7
    } action_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

/* hdl/urs_ctrl.sv */
// Controller FSM for the response segmenter: capture, execute, deliver.
// Depends on urs_pkg.
module urs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output urs_pkg::ctrl_cmd_t cmd
);
    import urs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_DONE);
    assign cmd.load = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.exec = (state_reg == ST_EXEC);

endmodule

/* hdl/urs_datapath.sv */
// Datapath for the response segmenter: response buffer, segment counters,
// status byte and result registers. Depends on urs_pkg.
module urs_datapath #(
    parameter int BUFFER_BYTES = urs_pkg::BUFFER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  urs_pkg::ctrl_cmd_t            cmd,
    input  urs_pkg::action_t              action,
    input  logic [7:0]                    data_byte,
    input  logic                          piece_end,
    input  logic [urs_pkg::TSIZE_W-1:0]   transfer_size,
    input  logic [urs_pkg::FETCH_W-1:0]   fetch_index,
    output logic                          accepted,
    output logic [urs_pkg::OFFSET_W-1:0]  chunk_offset,
    output logic [urs_pkg::LENGTH_W-1:0]  chunk_length,
    output logic                          end_of_message,
    output logic                          filler,
    output logic [7:0]                    status_byte,
    output logic [7:0]                    fetched_byte
);
    import urs_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int LW = $clog2(BUFFER_BYTES + 1);
    localparam int IW = (AW > FETCH_W) ? AW : FETCH_W;

    logic [7:0] mem [BUFFER_BYTES];

    action_t          op_reg;
    logic [7:0]       data_reg;
    logic             piece_reg;
    logic [TSIZE_W-1:0] tsize_reg;
    logic             fetch_ok_reg;
    logic [7:0]       rd_data_reg;

    logic [LW-1:0] length_reg, length_next;
    logic [LW-1:0] sent_reg, sent_next;
    logic [LW-1:0] flight_reg, flight_next;
    logic          pending_reg, pending_next;
    logic          xmit_reg, xmit_next;
    logic [7:0]    status_reg, status_next;

    logic                res_accepted_reg, res_accepted_next;
    logic [OFFSET_W-1:0] res_offset_reg, res_offset_next;
    logic [LENGTH_W-1:0] res_length_reg, res_length_next;
    logic                res_eom_reg, res_eom_next;
    logic                res_filler_reg, res_filler_next;
    logic [7:0]          res_status_reg, res_status_next;
    logic [7:0]          res_fetched_reg, res_fetched_next;

    logic [IW-1:0] fidx_wide;
    logic          fetch_ok;
    logic [LW-1:0] remain;
    logic          clamp;
    logic [LW-1:0] chunk;
    logic [LW:0]   sent_sum;
    logic          all_sent;
    logic          full;
    logic          wr_en;

    assign fidx_wide = IW'(fetch_index);
    assign fetch_ok  = ({1'b0, fidx_wide} < (IW + 1)'(BUFFER_BYTES));

    // Input capture and buffer read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= action;
            data_reg     <= data_byte;
            piece_reg    <= piece_end;
            tsize_reg    <= transfer_size;
            fetch_ok_reg <= fetch_ok;
            if (fetch_ok)
            begin
                rd_data_reg <= mem[fidx_wide[AW-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[length_reg[AW-1:0]] <= data_reg;
        end
    end

    assign remain   = length_reg - sent_reg;
    assign clamp    = (tsize_reg != '0) && (TSIZE_W'(remain) > tsize_reg);
    assign chunk    = clamp ? LW'(tsize_reg) : remain;
    assign sent_sum = (LW + 1)'(sent_reg) + (LW + 1)'(flight_reg);
    assign all_sent = (sent_sum >= (LW + 1)'(length_reg));
    assign full     = (length_reg >= LW'(BUFFER_BYTES));
    assign wr_en    = cmd.exec && (op_reg == ACT_APPEND) && !xmit_reg && !full;

    always_comb
    begin
        length_next       = length_reg;
        sent_next         = sent_reg;
        flight_next       = flight_reg;
        pending_next      = pending_reg;
        xmit_next         = xmit_reg;
        status_next       = status_reg;
        res_accepted_next = 1'b1;
        res_offset_next   = '0;
        res_length_next   = '0;
        res_eom_next      = 1'b0;
        res_filler_next   = 1'b0;
        res_fetched_next  = '0;
        case (op_reg)
            ACT_APPEND:
            begin
                if (xmit_reg || full)
                begin
                    res_accepted_next = 1'b0;
                end
                else
                begin
                    length_next = length_reg + 1'b1;
                    if (piece_reg)
                    begin
                        pending_next = 1'b1;
                        status_next  = status_reg | STB_MAV;
                    end
                end
            end
            ACT_IN_REQUEST:
            begin
                if (pending_reg && (length_reg > sent_reg))
                begin
                    res_offset_next = OFFSET_W'(sent_reg);
                    res_length_next = LENGTH_W'(chunk);
                    res_eom_next    = !clamp;
                    flight_next     = chunk;
                end
                else
                begin
                    flight_next     = '0;
                    res_length_next = LENGTH_W'(1);
                    res_eom_next    = 1'b1;
                    res_filler_next = 1'b1;
                end
                xmit_next = 1'b1;
            end
            ACT_IN_COMPLETE:
            begin
                sent_next   = sent_sum[LW-1:0];
                flight_next = '0;
                xmit_next   = 1'b0;
                if (all_sent)
                begin
                    length_next  = '0;
                    sent_next    = '0;
                    pending_next = 1'b0;
                    status_next  = status_reg & ~STB_MAV;
                end
            end
            ACT_READ_STATUS:
            begin
                status_next = status_reg & ~STB_SRQ;
            end
            ACT_SET_SRQ:
            begin
                status_next = status_reg | STB_SRQ;
            end
            ACT_CLEAR_OUT:
            begin
                length_next  = '0;
                sent_next    = '0;
                flight_next  = '0;
                pending_next = 1'b0;
                xmit_next    = 1'b0;
                status_next  = '0;
            end
            ACT_CLEAR_IN:
            begin
                length_next  = '0;
                sent_next    = '0;
                flight_next  = '0;
                pending_next = 1'b0;
                xmit_next    = 1'b0;
                status_next  = status_reg & ~STB_MAV;
            end
            ACT_FETCH:
            begin
                res_fetched_next = fetch_ok_reg ? rd_data_reg : 8'h00;
            end
            default:
            begin
                res_accepted_next = 1'b1;
            end
        endcase
        res_status_next = (op_reg == ACT_READ_STATUS) ? status_reg : status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg  <= '0;
            sent_reg    <= '0;
            flight_reg  <= '0;
            pending_reg <= 1'b0;
            xmit_reg    <= 1'b0;
            status_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            length_reg  <= length_next;
            sent_reg    <= sent_next;
            flight_reg  <= flight_next;
            pending_reg <= pending_next;
            xmit_reg    <= xmit_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_accepted_reg <= res_accepted_next;
            res_offset_reg   <= res_offset_next;
            res_length_reg   <= res_length_next;
            res_eom_reg      <= res_eom_next;
            res_filler_reg   <= res_filler_next;
            res_status_reg   <= res_status_next;
            res_fetched_reg  <= res_fetched_next;
        end
    end

    assign accepted       = res_accepted_reg;
    assign chunk_offset   = res_offset_reg;
    assign chunk_length   = res_length_reg;
    assign end_of_message = res_eom_reg;
    assign filler         = res_filler_reg;
    assign status_byte    = res_status_reg;
    assign fetched_byte   = res_fetched_reg;

endmodule

/* hdl/usbtmc_response_segmenter_top.sv */
// Top level of the USBTMC bulk-IN response segmenter.
// Depends on urs_pkg, urs_ctrl and urs_datapath.
// An input transaction is captured, executed and then presented as a registered result.
// A new transaction is accepted only after the previous result has been taken, as set by the
// controller's capture/execute/deliver sequence around the registered buffer read.
// Reset clears counters, flags and status bits; buffer contents stay undefined.
module usbtmc_response_segmenter_top #(
    parameter int BUFFER_BYTES = urs_pkg::BUFFER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // data_byte[7:0], transfer_size[39:8], fetch_index[51:40], zero pad
    input  logic [urs_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[2:0]
    input  logic [urs_pkg::ACTION_W-1:0]    s_tuser,
    // piece_end
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accepted[0], chunk_offset[12:1], chunk_length[25:13],
    // status_byte[33:26], fetched_byte[41:34], zero pad
    output logic [urs_pkg::M_TDATA_W-1:0]   m_tdata,
    // filler[0]
    output logic                            m_tuser,
    // end_of_message
    output logic                            m_tlast
);
    import urs_pkg::*;

    ctrl_cmd_t           cmd;
    logic                accepted;
    logic [OFFSET_W-1:0] chunk_offset;
    logic [LENGTH_W-1:0] chunk_length;
    logic [7:0]          status_byte;
    logic [7:0]          fetched_byte;

    urs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    urs_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .action         (action_t'(s_tuser)),
        .data_byte      (s_tdata[7:0]),
        .piece_end      (s_tlast),
        .transfer_size  (s_tdata[39:8]),
        .fetch_index    (s_tdata[51:40]),
        .accepted       (accepted),
        .chunk_offset   (chunk_offset),
        .chunk_length   (chunk_length),
        .end_of_message (m_tlast),
        .filler         (m_tuser),
        .status_byte    (status_byte),
        .fetched_byte   (fetched_byte)
    );

    assign m_tdata = {6'b0, fetched_byte, status_byte, chunk_length, chunk_offset, accepted};

endmodule

/* hdl/urs_chk.sv */
// Port-level checker for usbtmc_response_segmenter_top, bound to the top level.
// Depends on urs_pkg.
module urs_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [urs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);
    import urs_pkg::*;

    // one transaction in the block at a time
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("result not valid two cycles after input transaction");

    a_filler_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[0]
            && (m_tdata[12:1] == '0) && (m_tdata[25:13] == LENGTH_W'(1))))
        else $error("malformed filler chunk");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed while stalled");

endmodule

bind usbtmc_response_segmenter_top urs_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
